// ----- rtl/rbmf_pkg.sv -----
// Package for the RGB box mean filter: default sizes, the queued item type
// and the back-end state encoding. Depends on nothing.
package rbmf_pkg;

    // Default size limits handed to the top-level parameters.
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_HALF = 7;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
    localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
    localparam logic [1:0] REG_IMAGE_COLS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [2:0]  RST_HALF_WIDTH = 3'd1;
    localparam logic [10:0] RST_IMAGE_ROWS = 11'd1024;
    localparam logic [10:0] RST_IMAGE_COLS = 11'd1024;

    // Item modes.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // One word as it waits in the queue.
    typedef struct packed {
        logic       mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_DRAIN,
        S_DIV,
        S_OUT
    } eng_state_t;

endpackage

// ----- rtl/rbmf_if.sv -----
// Stream interfaces for the RGB box mean filter: pixel input and mean output.
// Depends on nothing.
interface rbmf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface rbmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ----- rtl/rgb_box_mean_filter.sv -----
// Top level of the RGB box mean filter: configuration registers, front queue
// and back end. Depends on rbmf_pkg, rbmf_if, rbmf_front and rbmf_engine.
//
// Usage: pixels of a frame enter in raster order on pix_in (mode 0); flush
// words (mode 1) drain the results still pending after the last pixel. Each
// word yields at most one result on pix_out, the clipped-window mean of one
// pixel, with frame_end set on the last pixel of the frame.
// Flow: a word that yields no result passes IDLE and CHECK in the back end;
// one that yields a result also reads its in-image window pixels from the
// line store, one a cycle, then divides the sum, one quotient bit a cycle.
// Results lag their pixels by up to half_width rows plus half_width pixels.
// A four-word queue lets the source run ahead while the back end works; the
// output register holds a result while the receiver stalls, and the back end
// waits for it without losing the result.
// Reset clears the registers to their defaults and empties the queue; the
// line store needs no clearing. The user must write registers over the APB
// port only when the block is idle; the block does not enforce it.
// A write to any of the three registers restarts the frame.
module rgb_box_mean_filter #(
    parameter int MAX_COLS = rbmf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = rbmf_pkg::DEF_MAX_ROWS,
    parameter int MAX_HALF = rbmf_pkg::DEF_MAX_HALF
) (
    input  logic        clk,
    input  logic        rst_n,
    rbmf_in_if.sink     pix_in,
    rbmf_out_if.source  pix_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]      half_width_reg;
    logic [10:0]     image_rows_reg;
    logic [10:0]     image_cols_reg;
    logic            cfg_wr;
    logic            cfg_clear;
    rbmf_pkg::item_t item;
    logic            item_vld;
    logic            item_pop;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_clear = cfg_wr && ((paddr[3:2] == rbmf_pkg::REG_HALF_WIDTH) ||
                                  (paddr[3:2] == rbmf_pkg::REG_IMAGE_ROWS) ||
                                  (paddr[3:2] == rbmf_pkg::REG_IMAGE_COLS));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= rbmf_pkg::RST_HALF_WIDTH;
            image_rows_reg <= rbmf_pkg::RST_IMAGE_ROWS;
            image_cols_reg <= rbmf_pkg::RST_IMAGE_COLS;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                rbmf_pkg::REG_HALF_WIDTH: half_width_reg <= pwdata[2:0];
                rbmf_pkg::REG_IMAGE_ROWS: image_rows_reg <= pwdata[10:0];
                rbmf_pkg::REG_IMAGE_COLS: image_cols_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            rbmf_pkg::REG_HALF_WIDTH: prdata = {29'd0, half_width_reg};
            rbmf_pkg::REG_IMAGE_ROWS: prdata = {21'd0, image_rows_reg};
            rbmf_pkg::REG_IMAGE_COLS: prdata = {21'd0, image_cols_reg};
            default:                  prdata = '0;
        endcase
    end

    rbmf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .item     (item),
        .item_vld (item_vld),
        .item_pop (item_pop)
    );

    rbmf_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_HALF (MAX_HALF)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .half_width (half_width_reg),
        .image_rows (image_rows_reg),
        .image_cols (image_cols_reg),
        .cfg_clear  (cfg_clear),
        .item       (item),
        .item_vld   (item_vld),
        .item_pop   (item_pop),
        .pix_out    (pix_out)
    );

endmodule

// ----- rtl/rbmf_front.sv -----
// Front end of the RGB box mean filter: accepts words and queues them for the
// back end. Depends on rbmf_pkg and rbmf_in_if.
module rbmf_front (
    input  logic           clk,
    input  logic           rst_n,
    rbmf_in_if.sink        pix_in,
    output rbmf_pkg::item_t item,
    output logic           item_vld,
    input  logic           item_pop
);

    localparam int PTR_W = $clog2(rbmf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rbmf_pkg::QUEUE_DEPTH + 1);

    rbmf_pkg::item_t  queue_mem [rbmf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    // A word is taken whenever a slot is free.
    assign pix_in.ready = (count_reg != CNT_W'(rbmf_pkg::QUEUE_DEPTH));
    assign push         = pix_in.valid && pix_in.ready;
    assign pop          = item_pop && item_vld;
    assign item_vld     = (count_reg != '0);
    assign item         = queue_mem[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{mode: pix_in.mode, blue: pix_in.blue_in,
                                       green: pix_in.green_in, red: pix_in.red_in};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rbmf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rbmf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rbmf_engine.sv -----
// Back end of the RGB box mean filter: line store, window sweep, serial divide
// and output register. Depends on rbmf_pkg and rbmf_out_if.
module rbmf_engine #(
    parameter int MAX_COLS = rbmf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = rbmf_pkg::DEF_MAX_ROWS,
    parameter int MAX_HALF = rbmf_pkg::DEF_MAX_HALF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      half_width,
    input  logic [10:0]     image_rows,
    input  logic [10:0]     image_cols,
    input  logic            cfg_clear,
    input  rbmf_pkg::item_t item,
    input  logic            item_vld,
    output logic            item_pop,
    rbmf_out_if.source      pix_out
);

    localparam int RING   = 2 * MAX_HALF + 2;
    localparam int RING_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int DEPTH  = RING * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIN    = 2 * MAX_HALF + 1;
    localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
    localparam int CNT_W  = $clog2(WIN * WIN + 1);
    localparam int DIV_W  = $clog2(SUM_W + 1);

    rbmf_pkg::eng_state_t state_reg, state_next;

    logic [23:0]       mem [DEPTH];
    logic [23:0]       rdata_reg;

    logic [2:0]        eff_h;
    logic [ROW_W-1:0]  eff_rows;
    logic [COL_W-1:0]  eff_cols;

    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next, out_ring_reg, out_ring_next;
    logic [ROW_W-1:0]  rd_row_reg, rd_row_next, rhi_reg, rhi_next;
    logic [COL_W-1:0]  rd_col_reg, rd_col_next, chi_reg, chi_next, clo_reg, clo_next;
    logic [RING_W-1:0] rd_ring_reg, rd_ring_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg;
    logic [SUM_W-1:0]  sr_reg, sr_next, sg_reg, sg_next, sb_reg, sb_next;
    logic [CNT_W-1:0]  rr_reg, rr_next, rg_reg, rg_next, rb_reg, rb_next;
    logic [DIV_W-1:0]  div_cnt_reg, div_cnt_next;
    logic              out_vld_reg, out_vld_next;
    logic [7:0]        ored_reg, ored_next, ogreen_reg, ogreen_next, oblue_reg, oblue_next;
    logic              oend_reg, oend_next;

    logic              in_done, out_done, restart, do_write, result_ready, out_load;
    logic              rd_en, rd_last;
    logic [ROW_W-1:0]  wr_row;
    logic [COL_W-1:0]  wr_col;
    logic [RING_W-1:0] wr_ring;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ROW_W:0]    rhi_c;
    logic [COL_W:0]    chi_c;
    logic [ROW_W-1:0]  rlo_c;
    logic [COL_W-1:0]  clo_c;
    logic [RING_W:0]   ring_lo_c;

    // Register values clamped to the supported sizes.
    always_comb
    begin
        eff_h    = (32'(half_width) > MAX_HALF) ? 3'(MAX_HALF) : half_width;
        eff_rows = (image_rows == '0) ? ROW_W'(1) :
                   (32'(image_rows) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(image_rows);
        eff_cols = (image_cols == '0) ? COL_W'(1) :
                   (32'(image_cols) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(image_cols);
    end

    // Frame progress and write position of an incoming pixel.
    always_comb
    begin
        in_done  = (in_row_reg == eff_rows);
        out_done = (out_row_reg == eff_rows);
        restart  = (item.mode == rbmf_pkg::MODE_PIXEL) && in_done && out_done;
        do_write = (state_reg == rbmf_pkg::S_IDLE) && item_vld &&
                   (item.mode == rbmf_pkg::MODE_PIXEL) && (restart || !in_done);
        wr_row   = restart ? '0 : in_row_reg;
        wr_col   = restart ? '0 : in_col_reg;
        wr_ring  = restart ? '0 : in_ring_reg;
        wr_addr  = ADDR_W'(wr_ring) * ADDR_W'(MAX_COLS) + ADDR_W'(wr_col);
        rd_addr  = ADDR_W'(rd_ring_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col_reg);
    end

    // Window bounds of the next result and whether its last pixel is in.
    always_comb
    begin
        rhi_c = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(eff_h);
        if (rhi_c > (ROW_W + 1)'(eff_rows - 1'b1))
        begin
            rhi_c = (ROW_W + 1)'(eff_rows - 1'b1);
        end
        chi_c = (COL_W + 1)'(out_col_reg) + (COL_W + 1)'(eff_h);
        if (chi_c > (COL_W + 1)'(eff_cols - 1'b1))
        begin
            chi_c = (COL_W + 1)'(eff_cols - 1'b1);
        end
        rlo_c = (out_row_reg > ROW_W'(eff_h)) ? out_row_reg - ROW_W'(eff_h) : '0;
        clo_c = (out_col_reg > COL_W'(eff_h)) ? out_col_reg - COL_W'(eff_h) : '0;
        ring_lo_c = (RING_W + 1)'(out_ring_reg) + (RING_W + 1)'(RING)
                    - (RING_W + 1)'(out_row_reg - rlo_c);
        if (ring_lo_c >= (RING_W + 1)'(RING))
        begin
            ring_lo_c = ring_lo_c - (RING_W + 1)'(RING);
        end
        result_ready = !out_done &&
                       ((rhi_c < (ROW_W + 1)'(in_row_reg)) ||
                        ((rhi_c == (ROW_W + 1)'(in_row_reg)) &&
                         (chi_c < (COL_W + 1)'(in_col_reg))));
    end

    // Line store: one write port for pixels, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_addr] <= {item.blue, item.green, item.red};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbmf_pkg::S_IDLE:  if (item_vld) state_next = rbmf_pkg::S_CHECK;
            rbmf_pkg::S_CHECK: state_next = result_ready ? rbmf_pkg::S_READ : rbmf_pkg::S_IDLE;
            rbmf_pkg::S_READ:  if (rd_last) state_next = rbmf_pkg::S_DRAIN;
            rbmf_pkg::S_DRAIN: state_next = rbmf_pkg::S_DIV;
            rbmf_pkg::S_DIV:
            begin
                if (div_cnt_reg == DIV_W'(SUM_W - 1))
                begin
                    state_next = rbmf_pkg::S_OUT;
                end
            end
            rbmf_pkg::S_OUT:   if (out_load) state_next = rbmf_pkg::S_IDLE;
            default:           state_next = rbmf_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item_pop = (state_reg == rbmf_pkg::S_IDLE) && item_vld;
        rd_en    = (state_reg == rbmf_pkg::S_READ);
        rd_last  = (rd_row_reg == rhi_reg) && (rd_col_reg == chi_reg);
        out_load = (state_reg == rbmf_pkg::S_OUT) && (!out_vld_reg || pix_out.ready);
    end

    // Datapath next values.
    always_comb
    begin
        logic [CNT_W:0] tr, tg, tb;
        logic           ger, geg, geb;

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_ring_next = in_ring_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        out_ring_next = out_ring_reg;
        rd_row_next  = rd_row_reg;
        rd_col_next  = rd_col_reg;
        rd_ring_next = rd_ring_reg;
        rhi_next     = rhi_reg;
        chi_next     = chi_reg;
        clo_next     = clo_reg;
        cnt_next     = cnt_reg;
        sr_next      = sr_reg;
        sg_next      = sg_reg;
        sb_next      = sb_reg;
        rr_next      = rr_reg;
        rg_next      = rg_reg;
        rb_next      = rb_reg;
        div_cnt_next = div_cnt_reg;
        out_vld_next = out_vld_reg && !pix_out.ready;
        ored_next    = ored_reg;
        ogreen_next  = ogreen_reg;
        oblue_next   = oblue_reg;
        oend_next    = oend_reg;

        tr  = {rr_reg, sr_reg[SUM_W-1]};
        tg  = {rg_reg, sg_reg[SUM_W-1]};
        tb  = {rb_reg, sb_reg[SUM_W-1]};
        ger = (tr >= {1'b0, cnt_reg});
        geg = (tg >= {1'b0, cnt_reg});
        geb = (tb >= {1'b0, cnt_reg});

        // Pixel write: a pixel after a finished frame begins a new one.
        if (item_pop && (item.mode == rbmf_pkg::MODE_PIXEL) && restart)
        begin
            out_row_next  = '0;
            out_col_next  = '0;
            out_ring_next = '0;
        end
        if (do_write)
        begin
            if (wr_col == eff_cols - 1'b1)
            begin
                in_col_next  = '0;
                in_row_next  = wr_row + 1'b1;
                in_ring_next = (wr_ring == RING_W'(RING - 1)) ? '0 : wr_ring + 1'b1;
            end
            else
            begin
                in_col_next  = wr_col + 1'b1;
                in_row_next  = wr_row;
                in_ring_next = wr_ring;
            end
        end

        // Set up the window sweep.
        if ((state_reg == rbmf_pkg::S_CHECK) && result_ready)
        begin
            rd_row_next  = rlo_c;
            rd_col_next  = clo_c;
            rd_ring_next = RING_W'(ring_lo_c);
            rhi_next     = ROW_W'(rhi_c);
            chi_next     = COL_W'(chi_c);
            clo_next     = clo_c;
            cnt_next     = CNT_W'((ROW_W'(rhi_c) - rlo_c + 1'b1) *
                                  (COL_W'(chi_c) - clo_c + 1'b1));
            sr_next      = '0;
            sg_next      = '0;
            sb_next      = '0;
        end

        // Walk the window row by row.
        if (state_reg == rbmf_pkg::S_READ)
        begin
            if (rd_col_reg == chi_reg)
            begin
                rd_col_next  = clo_reg;
                rd_row_next  = rd_row_reg + 1'b1;
                rd_ring_next = (rd_ring_reg == RING_W'(RING - 1)) ? '0 : rd_ring_reg + 1'b1;
            end
            else
            begin
                rd_col_next = rd_col_reg + 1'b1;
            end
        end

        // Accumulate the pixels that come back from the store.
        if (rd_vld_reg)
        begin
            sr_next = sr_reg + SUM_W'(rdata_reg[7:0]);
            sg_next = sg_reg + SUM_W'(rdata_reg[15:8]);
            sb_next = sb_reg + SUM_W'(rdata_reg[23:16]);
        end

        if (state_reg == rbmf_pkg::S_DRAIN)
        begin
            rr_next      = '0;
            rg_next      = '0;
            rb_next      = '0;
            div_cnt_next = '0;
        end

        // One quotient bit a cycle for each channel.
        if (state_reg == rbmf_pkg::S_DIV)
        begin
            rr_next      = ger ? CNT_W'(tr - {1'b0, cnt_reg}) : CNT_W'(tr);
            rg_next      = geg ? CNT_W'(tg - {1'b0, cnt_reg}) : CNT_W'(tg);
            rb_next      = geb ? CNT_W'(tb - {1'b0, cnt_reg}) : CNT_W'(tb);
            sr_next      = {sr_reg[SUM_W-2:0], ger};
            sg_next      = {sg_reg[SUM_W-2:0], geg};
            sb_next      = {sb_reg[SUM_W-2:0], geb};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        // Hand the mean to the output register and step the output position.
        if (out_load)
        begin
            out_vld_next = 1'b1;
            ored_next    = sr_reg[7:0];
            ogreen_next  = sg_reg[7:0];
            oblue_next   = sb_reg[7:0];
            oend_next    = (out_row_reg == eff_rows - 1'b1) &&
                           (out_col_reg == eff_cols - 1'b1);
            if (out_col_reg == eff_cols - 1'b1)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_ring_next = (out_ring_reg == RING_W'(RING - 1)) ? '0 : out_ring_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        // A register write abandons the frame.
        if (cfg_clear)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_ring_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_ring_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rbmf_pkg::S_IDLE;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_ring_reg  <= in_ring_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_ring_reg <= out_ring_next;
            rd_vld_reg   <= rd_en;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_row_reg  <= rd_row_next;
        rd_col_reg  <= rd_col_next;
        rd_ring_reg <= rd_ring_next;
        rhi_reg     <= rhi_next;
        chi_reg     <= chi_next;
        clo_reg     <= clo_next;
        cnt_reg     <= cnt_next;
        sr_reg      <= sr_next;
        sg_reg      <= sg_next;
        sb_reg      <= sb_next;
        rr_reg      <= rr_next;
        rg_reg      <= rg_next;
        rb_reg      <= rb_next;
        div_cnt_reg <= div_cnt_next;
        ored_reg    <= ored_next;
        ogreen_reg  <= ogreen_next;
        oblue_reg   <= oblue_next;
        oend_reg    <= oend_next;
    end

    assign pix_out.valid     = out_vld_reg;
    assign pix_out.red_out   = ored_reg;
    assign pix_out.green_out = ogreen_reg;
    assign pix_out.blue_out  = oblue_reg;
    assign pix_out.frame_end = oend_reg;

    // The divisor is never zero while dividing.
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbmf_pkg::S_DIV |-> cnt_reg != '0)
        else $error("window count is zero during division");

    // The sweep never passes the bottom row of the window.
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbmf_pkg::S_READ |-> rd_row_reg <= rhi_reg)
        else $error("window sweep ran past its last row");

    // A held result is not overwritten by the next one.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !pix_out.ready |-> !out_load)
        else $error("output register loaded while its word is stalled");

endmodule
